### hdl/ckfs_pkg.sv
// shared types, codes and constants for the cosine knn flat search block
package ckfs_pkg;

    localparam int MAX_VECTORS_DEF   = 1024;
    localparam int MAX_LENGTH_DEF    = 64;
    localparam int MAX_NEIGHBORS_DEF = 16;
    localparam int ELEMENT_BITS_DEF  = 16;

    localparam int NORM_BITS  = 64;
    localparam int ROOT_BITS  = 17;
    localparam int DIV_BITS   = 2 * ROOT_BITS;
    localparam int SHIFT_BITS = 5;
    localparam int DIST_BITS  = 17;

    localparam logic [DIST_BITS-1:0] ONE_Q15 = 17'h08000;
    localparam logic [DIST_BITS-1:0] TWO_Q15 = 17'h10000;
    localparam logic [6:0]           LENGTH_RESET = 7'd64;

    localparam logic [1:0] FUNC_ADD   = 2'd0;
    localparam logic [1:0] FUNC_QUERY = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_LENGTH = 2'd3;

    localparam logic KIND_STATUS   = 1'b0;
    localparam logic KIND_NEIGHBOR = 1'b1;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [15:0] element_value;
        logic               last_element;
        logic               has_ext_id;
        logic [31:0]        ext_id;
        logic [4:0]         k_wanted;
    } ckfs_in_t;

    typedef struct packed {
        logic                 kind;
        logic [1:0]           status;
        logic [31:0]          result_id;
        logic [DIST_BITS-1:0] distance;
        logic [3:0]           rank;
        logic                 last;
    } ckfs_out_t;

    typedef struct packed {
        logic                  done;
        logic [ROOT_BITS-1:0]  root;
        logic [SHIFT_BITS-1:0] shift;
    } sqrt_res_t;

    typedef struct packed {
        logic                 done;
        logic [NORM_BITS-1:0] quo;
        logic                 round_up;
    } div_res_t;

endpackage

### hdl/ckfs_store.sv
// vector, query and id memories with registered read data
module ckfs_store import ckfs_pkg::*; #(
    parameter int MAX_VECTORS  = MAX_VECTORS_DEF,
    parameter int MAX_LENGTH   = MAX_LENGTH_DEF,
    parameter int ELEMENT_BITS = ELEMENT_BITS_DEF,
    localparam int VW = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1,
    localparam int LW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1,
    localparam int AW = (MAX_VECTORS * MAX_LENGTH > 1) ? $clog2(MAX_VECTORS * MAX_LENGTH) : 1
) (
    input  logic                    clk,
    input  logic                    vec_we,
    input  logic [AW-1:0]           vec_waddr,
    input  logic [ELEMENT_BITS-1:0] vec_wdata,
    input  logic [AW-1:0]           vec_raddr,
    output logic [ELEMENT_BITS-1:0] vec_rdata,
    input  logic                    qry_we,
    input  logic [LW-1:0]           qry_waddr,
    input  logic [ELEMENT_BITS-1:0] qry_wdata,
    input  logic [LW-1:0]           qry_raddr,
    output logic [ELEMENT_BITS-1:0] qry_rdata,
    input  logic                    id_we,
    input  logic [VW-1:0]           id_waddr,
    input  logic [31:0]             id_wdata,
    input  logic [VW-1:0]           id_raddr,
    output logic [31:0]             id_rdata
);

    logic [ELEMENT_BITS-1:0] vec_mem [MAX_VECTORS*MAX_LENGTH];
    logic [ELEMENT_BITS-1:0] qry_mem [MAX_LENGTH];
    logic [31:0]             id_mem  [MAX_VECTORS];

    always_ff @(posedge clk)
    begin
        if (vec_we)
        begin
            vec_mem[vec_waddr] <= vec_wdata;
        end
        vec_rdata <= vec_mem[vec_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (qry_we)
        begin
            qry_mem[qry_waddr] <= qry_wdata;
        end
        qry_rdata <= qry_mem[qry_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (id_we)
        begin
            id_mem[id_waddr] <= id_wdata;
        end
        id_rdata <= id_mem[id_raddr];
    end

endmodule

### hdl/ckfs_sqrt.sv
// normalizing integer square root, two bits of radicand per cycle
module ckfs_sqrt import ckfs_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [NORM_BITS-1:0] radicand,
    output sqrt_res_t            res
);

    typedef enum logic [2:0] {
        SQ_IDLE = 3'b001,
        SQ_NORM = 3'b010,
        SQ_ROOT = 3'b100
    } sq_state_t;

    localparam logic [NORM_BITS-1:0] NORM_LIMIT = 64'h1000_0000_0000_0000;
    localparam logic [NORM_BITS-1:0] TOP_BIT    = 64'h4000_0000_0000_0000;

    sq_state_t             state_reg;
    logic                  done_reg;
    logic [NORM_BITS-1:0]  x_reg;
    logic [NORM_BITS-1:0]  acc_reg;
    logic [NORM_BITS-1:0]  rbit_reg;
    logic [SHIFT_BITS-1:0] shift_reg;
    logic [NORM_BITS-1:0]  trial;
    logic                  fits;

    assign trial = acc_reg + rbit_reg;
    assign fits  = (x_reg >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SQ_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                state_reg <= SQ_NORM;
            end
            else
            begin
                unique case (state_reg)
                    SQ_IDLE: ;
                    SQ_NORM:
                    begin
                        if (x_reg >= NORM_LIMIT)
                        begin
                            state_reg <= SQ_ROOT;
                        end
                    end
                    SQ_ROOT:
                    begin
                        if (rbit_reg == 64'd1)
                        begin
                            state_reg <= SQ_IDLE;
                            done_reg  <= 1'b1;
                        end
                    end
                    default: state_reg <= SQ_IDLE;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg     <= radicand;
            shift_reg <= '0;
        end
        else if (state_reg == SQ_NORM)
        begin
            if (x_reg < NORM_LIMIT)
            begin
                x_reg     <= x_reg << 2;
                shift_reg <= shift_reg + SHIFT_BITS'(1);
            end
            else
            begin
                acc_reg  <= '0;
                rbit_reg <= TOP_BIT;
            end
        end
        else if (state_reg == SQ_ROOT)
        begin
            if (fits)
            begin
                x_reg   <= x_reg - trial;
                acc_reg <= (acc_reg >> 1) + rbit_reg;
            end
            else
            begin
                acc_reg <= acc_reg >> 1;
            end
            rbit_reg <= rbit_reg >> 2;
        end
    end

    // root of the shifted norm with its 15 low bits dropped
    assign res.done  = done_reg;
    assign res.root  = acc_reg[ROOT_BITS+14:15];
    assign res.shift = shift_reg;

endmodule

### hdl/ckfs_div.sv
// restoring divider, one quotient bit per cycle, with round-half-up flag
module ckfs_div import ckfs_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [NORM_BITS-1:0] dividend,
    input  logic [DIV_BITS-1:0]  divisor,
    output div_res_t             res
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [5:0]           cnt_reg;
    logic [DIV_BITS-1:0]  rem_reg;
    logic [NORM_BITS-1:0] quo_reg;
    logic [DIV_BITS-1:0]  d_reg;
    logic [DIV_BITS:0]    trial;
    logic                 ge;

    assign trial = {rem_reg, quo_reg[NORM_BITS-1]};
    assign ge    = (trial >= {1'b0, d_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            d_reg   <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? DIV_BITS'(trial - {1'b0, d_reg}) : DIV_BITS'(trial);
            quo_reg <= {quo_reg[NORM_BITS-2:0], ge};
        end
    end

    assign res.done     = done_reg;
    assign res.quo      = quo_reg;
    assign res.round_up = ({rem_reg, 1'b0} >= {1'b0, d_reg});

endmodule

### hdl/cosine_knn_flat_search.sv
// top level of the cosine knn flat search block
// a status result follows in the cycle after the last element, and element transfers are taken
//   back to back (busy stays low)
// a search walks the store: per stored vector it sums dot products, takes two square roots
//   (query norm first, up to 30 normalize steps each), scales, divides and inserts; a zero norm
//   skips roots and divide, an overflow skips the divide; the k neighbors then leave one per cycle
// reset: store empty, element position 0, vector_length 64, no result pending; the receiver
//   cannot stall, every result is strobed for exactly one cycle
module cosine_knn_flat_search import ckfs_pkg::*; #(
    parameter int MAX_VECTORS   = MAX_VECTORS_DEF,
    parameter int MAX_LENGTH    = MAX_LENGTH_DEF,
    parameter int MAX_NEIGHBORS = MAX_NEIGHBORS_DEF,
    parameter int ELEMENT_BITS  = ELEMENT_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  ckfs_in_t  item,
    input  logic      cfg_we,
    input  logic [6:0] cfg_wdata,
    output ckfs_out_t result,
    output logic      result_valid
);

    localparam int VW = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1;
    localparam int LW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
    localparam int AW = (MAX_VECTORS * MAX_LENGTH > 1) ? $clog2(MAX_VECTORS * MAX_LENGTH) : 1;
    localparam int CW = $clog2(MAX_VECTORS + 1);
    localparam int PW = $clog2(MAX_LENGTH + 2);
    localparam int NW = $clog2(MAX_NEIGHBORS + 1);
    localparam int JW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
    localparam int EB = ELEMENT_BITS;

    localparam logic [AW-1:0] LEN_STEP = AW'(MAX_LENGTH);

    // search sequencer
    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_DOT    = 9'b000000010,
        S_ROOTQ  = 9'b000000100,
        S_ROOTV  = 9'b000001000,
        S_SCALE  = 9'b000010000,
        S_DIV    = 9'b000100000,
        S_FIN    = 9'b001000000,
        S_INSERT = 9'b010000000,
        S_EMIT   = 9'b100000000
    } state_t;

    state_t state_reg;

    // configuration and store bookkeeping
    logic [6:0]    length_reg;
    logic [CW-1:0] count_reg;
    logic [PW-1:0] pos_reg;
    logic [AW-1:0] add_base_reg;

    // scan state
    logic [CW-1:0] slot_reg;
    logic [AW-1:0] base_reg;
    logic [PW-1:0] rd_idx_reg;
    logic          rd_v1_reg;
    logic          prod_v_reg;
    logic [NW-1:0] kk_reg;

    logic [NORM_BITS-1:0]  pdot_reg, pq_reg, pv_reg;
    logic [NORM_BITS-1:0]  dot_reg, nq_reg, nv_reg;
    logic [ROOT_BITS-1:0]  rq_reg, rv_reg;
    logic [SHIFT_BITS-1:0] sq_reg, sv_reg;
    logic [DIST_BITS-1:0]  cval_reg;
    logic [DIST_BITS-1:0]  dist_reg;

    // best list, sorted by distance, ties keep the earlier slot
    logic [DIST_BITS-1:0] best_dist_reg [MAX_NEIGHBORS];
    logic [VW-1:0]        best_slot_reg [MAX_NEIGHBORS];
    logic [NW-1:0]        best_count_reg;

    // neighbor emit
    logic [NW-1:0]        emit_idx_reg;
    logic                 pend_reg;
    logic [DIST_BITS-1:0] pend_dist_reg;
    logic [3:0]           pend_rank_reg;
    logic                 pend_last_reg;

    logic      result_valid_reg;
    ckfs_out_t result_reg;

    // memory ports
    logic          vec_we, qry_we, id_we;
    logic [AW-1:0] vec_waddr, vec_raddr;
    logic [LW-1:0] qry_waddr, qry_raddr;
    logic [VW-1:0] id_waddr, id_raddr;
    logic [EB-1:0] elem, vec_rdata, qry_rdata;
    logic [31:0]   id_wdata, id_rdata;
    logic [47:0]   elem_ext;

    logic          accept;
    logic [PW-1:0] eff_len;
    logic [31:0]   len32;
    logic          len_ok;
    logic          full;
    logic [31:0]   k32;
    logic [NW-1:0] kk;
    logic          emit_status;
    logic [1:0]    stat;
    logic          go_scan;

    logic          rd_active;
    logic          dot_done;
    logic          norm_zero;
    logic          scan_end;
    logic          dot_init;

    logic signed [2*EB-1:0] pdot_w, pq_w, pv_w;

    sqrt_res_t            sqrt_res;
    logic                 sqrt_start;
    logic [NORM_BITS-1:0] sqrt_arg;

    div_res_t             div_res;
    logic                 div_start;
    logic [DIV_BITS-1:0]  d_prod;
    logic signed [6:0]    expo;
    logic [5:0]           sh;
    logic [NORM_BITS-1:0] mag;
    logic [NORM_BITS-1:0] m_val;
    logic                 ovf;
    logic [NORM_BITS-1:0] c_full;

    logic [NW-1:0] ins_pos;
    logic [NW-1:0] ins_lim;
    logic          ins_take;

    assign busy   = (state_reg != S_IDLE) || pend_reg;
    assign accept = start && !busy;

    // element taken as ELEMENT_BITS two's complement bits of the field
    assign elem_ext = {32'b0, item.element_value};
    assign elem     = elem_ext[EB-1:0];

    // effective length: zero acts as one, capped at the store row length
    always_comb
    begin
        len32 = 32'(length_reg);
        if (len32 == 32'd0)
        begin
            len32 = 32'd1;
        end
        else if (len32 > 32'(MAX_LENGTH))
        begin
            len32 = 32'(MAX_LENGTH);
        end
        eff_len = PW'(len32);
    end

    assign len_ok = (({1'b0, pos_reg} + (PW+1)'(1)) == {1'b0, eff_len});
    assign full   = (count_reg == CW'(MAX_VECTORS));

    // neighbors wanted, capped by list size and store fill
    always_comb
    begin
        k32 = 32'(item.k_wanted);
        if (k32 > 32'(MAX_NEIGHBORS))
        begin
            k32 = 32'(MAX_NEIGHBORS);
        end
        if (k32 > 32'(count_reg))
        begin
            k32 = 32'(count_reg);
        end
        kk = NW'(k32);
    end

    // decision for an accepted transfer
    always_comb
    begin
        emit_status = 1'b0;
        stat        = ST_OK;
        go_scan     = 1'b0;
        if (accept)
        begin
            unique case (item.func)
                FUNC_CLEAR: emit_status = 1'b1;
                FUNC_ADD, FUNC_QUERY:
                begin
                    if (item.last_element)
                    begin
                        emit_status = 1'b1;
                        if (!len_ok)
                        begin
                            stat = ST_LENGTH;
                        end
                        else if (item.func == FUNC_ADD)
                        begin
                            stat = full ? ST_FULL : ST_OK;
                        end
                        else if (kk == '0)
                        begin
                            stat = ST_EMPTY;
                        end
                        else
                        begin
                            emit_status = 1'b0;
                            go_scan     = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // memory writes from element transfers
    assign qry_we    = accept && (item.func == FUNC_QUERY) && (pos_reg < eff_len);
    assign qry_waddr = pos_reg[LW-1:0];
    assign vec_we    = accept && (item.func == FUNC_ADD) && (pos_reg < eff_len) && !full;
    assign vec_waddr = add_base_reg + AW'(pos_reg);
    assign id_we     = accept && (item.func == FUNC_ADD) && item.last_element && len_ok && !full;
    assign id_waddr  = VW'(count_reg);
    assign id_wdata  = item.has_ext_id ? item.ext_id : 32'(count_reg);

    // scan reads: query element and stored element at the same index
    assign rd_active = (state_reg == S_DOT) && (rd_idx_reg < eff_len);
    assign vec_raddr = base_reg + AW'(rd_idx_reg);
    assign qry_raddr = rd_idx_reg[LW-1:0];
    assign id_raddr  = best_slot_reg[emit_idx_reg[JW-1:0]];
    assign dot_done  = (state_reg == S_DOT) && !rd_active && !rd_v1_reg && !prod_v_reg;
    assign norm_zero = (nq_reg == '0) || (nv_reg == '0);
    assign scan_end  = ((slot_reg + CW'(1)) == count_reg);
    assign dot_init  = go_scan || ((state_reg == S_INSERT) && !scan_end);

    assign pdot_w = $signed(qry_rdata) * $signed(vec_rdata);
    assign pq_w   = $signed(qry_rdata) * $signed(qry_rdata);
    assign pv_w   = $signed(vec_rdata) * $signed(vec_rdata);

    // one root unit serves both norms, query first
    assign sqrt_start = (dot_done && !norm_zero) || ((state_reg == S_ROOTQ) && sqrt_res.done);
    assign sqrt_arg   = (state_reg == S_DOT) ? nq_reg : nv_reg;

    // scale: |dot| * 2^(sq+sv-15), overflow past 64 bits saturates the cosine
    assign d_prod = rq_reg * rv_reg;
    assign mag    = dot_reg[NORM_BITS-1] ? (NORM_BITS'(0) - dot_reg) : dot_reg;

    always_comb
    begin
        expo  = $signed({2'b0, sq_reg}) + $signed({2'b0, sv_reg}) - 7'sd15;
        ovf   = 1'b0;
        if (expo >= 7'sd0)
        begin
            sh    = expo[5:0];
            m_val = mag << sh;
            if (sh != 6'd0)
            begin
                ovf = ((mag >> (7'd64 - {1'b0, sh})) != '0);
            end
        end
        else
        begin
            sh    = 6'(-expo);
            m_val = mag >> sh;
        end
    end

    assign div_start = (state_reg == S_SCALE);
    assign c_full    = div_res.quo + NORM_BITS'(div_res.round_up);

    // insertion point in the sorted list
    always_comb
    begin
        ins_pos = '0;
        for (int j = 0; j < MAX_NEIGHBORS; j++)
        begin
            if ((NW'(j) < best_count_reg) && (best_dist_reg[j] <= dist_reg))
            begin
                ins_pos = ins_pos + NW'(1);
            end
        end
        ins_lim  = (best_count_reg < kk_reg) ? best_count_reg : (kk_reg - NW'(1));
        ins_take = (ins_pos < kk_reg);
    end

    ckfs_store #(
        .MAX_VECTORS  (MAX_VECTORS),
        .MAX_LENGTH   (MAX_LENGTH),
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_store (
        .clk       (clk),
        .vec_we    (vec_we),
        .vec_waddr (vec_waddr),
        .vec_wdata (elem),
        .vec_raddr (vec_raddr),
        .vec_rdata (vec_rdata),
        .qry_we    (qry_we),
        .qry_waddr (qry_waddr),
        .qry_wdata (elem),
        .qry_raddr (qry_raddr),
        .qry_rdata (qry_rdata),
        .id_we     (id_we),
        .id_waddr  (id_waddr),
        .id_wdata  (id_wdata),
        .id_raddr  (id_raddr),
        .id_rdata  (id_rdata)
    );

    ckfs_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sqrt_arg),
        .res      (sqrt_res)
    );

    ckfs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (m_val),
        .divisor  (d_prod),
        .res      (div_res)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            length_reg       <= LENGTH_RESET;
            count_reg        <= '0;
            pos_reg          <= '0;
            add_base_reg     <= '0;
            slot_reg         <= '0;
            base_reg         <= '0;
            rd_idx_reg       <= '0;
            rd_v1_reg        <= 1'b0;
            prod_v_reg       <= 1'b0;
            kk_reg           <= '0;
            best_count_reg   <= '0;
            emit_idx_reg     <= '0;
            pend_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                length_reg <= cfg_wdata;
            end

            result_valid_reg <= emit_status || pend_reg;
            pend_reg         <= (state_reg == S_EMIT);
            rd_v1_reg        <= rd_active;
            prod_v_reg       <= rd_v1_reg;

            if (rd_active)
            begin
                rd_idx_reg <= rd_idx_reg + PW'(1);
            end

            if (accept)
            begin
                unique case (item.func)
                    FUNC_CLEAR:
                    begin
                        count_reg      <= '0;
                        pos_reg        <= '0;
                        add_base_reg   <= '0;
                        best_count_reg <= '0;
                    end
                    FUNC_ADD, FUNC_QUERY:
                    begin
                        if (!item.last_element)
                        begin
                            if (pos_reg < PW'(MAX_LENGTH + 1))
                            begin
                                pos_reg <= pos_reg + PW'(1);
                            end
                        end
                        else
                        begin
                            pos_reg <= '0;
                            if (id_we)
                            begin
                                count_reg    <= count_reg + CW'(1);
                                add_base_reg <= add_base_reg + LEN_STEP;
                            end
                        end
                    end
                    default: ;
                endcase
            end

            if (go_scan)
            begin
                kk_reg         <= kk;
                best_count_reg <= '0;
                slot_reg       <= '0;
                base_reg       <= '0;
                rd_idx_reg     <= '0;
                state_reg      <= S_DOT;
            end
            else
            begin
                unique case (state_reg)
                    S_IDLE: ;
                    S_DOT:
                    begin
                        if (dot_done)
                        begin
                            state_reg <= norm_zero ? S_INSERT : S_ROOTQ;
                        end
                    end
                    S_ROOTQ:
                    begin
                        if (sqrt_res.done)
                        begin
                            state_reg <= S_ROOTV;
                        end
                    end
                    S_ROOTV:
                    begin
                        if (sqrt_res.done)
                        begin
                            state_reg <= S_SCALE;
                        end
                    end
                    S_SCALE: state_reg <= ovf ? S_INSERT : S_DIV;
                    S_DIV:
                    begin
                        if (div_res.done)
                        begin
                            state_reg <= S_FIN;
                        end
                    end
                    S_FIN: state_reg <= S_INSERT;
                    S_INSERT:
                    begin
                        if (ins_take && (best_count_reg < kk_reg))
                        begin
                            best_count_reg <= best_count_reg + NW'(1);
                        end
                        if (scan_end)
                        begin
                            emit_idx_reg <= '0;
                            state_reg    <= S_EMIT;
                        end
                        else
                        begin
                            slot_reg   <= slot_reg + CW'(1);
                            base_reg   <= base_reg + LEN_STEP;
                            rd_idx_reg <= '0;
                            state_reg  <= S_DOT;
                        end
                    end
                    S_EMIT:
                    begin
                        emit_idx_reg <= emit_idx_reg + NW'(1);
                        if ((emit_idx_reg + NW'(1)) == best_count_reg)
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                    default: state_reg <= S_IDLE;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        pdot_reg <= NORM_BITS'(pdot_w);
        pq_reg   <= NORM_BITS'(pq_w);
        pv_reg   <= NORM_BITS'(pv_w);

        if (dot_init)
        begin
            dot_reg <= '0;
            nq_reg  <= '0;
            nv_reg  <= '0;
        end
        else if (prod_v_reg)
        begin
            dot_reg <= dot_reg + pdot_reg;
            nq_reg  <= nq_reg + pq_reg;
            nv_reg  <= nv_reg + pv_reg;
        end

        if ((state_reg == S_ROOTQ) && sqrt_res.done)
        begin
            rq_reg <= sqrt_res.root;
            sq_reg <= sqrt_res.shift;
        end
        if ((state_reg == S_ROOTV) && sqrt_res.done)
        begin
            rv_reg <= sqrt_res.root;
            sv_reg <= sqrt_res.shift;
        end

        // zero norm reads as distance one
        if (dot_done && norm_zero)
        begin
            dist_reg <= ONE_Q15;
        end
        if ((state_reg == S_SCALE) && ovf)
        begin
            dist_reg <= dot_reg[NORM_BITS-1] ? TWO_Q15 : '0;
        end
        if ((state_reg == S_DIV) && div_res.done)
        begin
            cval_reg <= (c_full > NORM_BITS'(ONE_Q15)) ? ONE_Q15 : c_full[DIST_BITS-1:0];
        end
        if (state_reg == S_FIN)
        begin
            dist_reg <= dot_reg[NORM_BITS-1] ? (ONE_Q15 + cval_reg) : (ONE_Q15 - cval_reg);
        end

        // shift the tail down one place and drop the new entry in
        if ((state_reg == S_INSERT) && ins_take)
        begin
            for (int j = 0; j < MAX_NEIGHBORS; j++)
            begin
                if (NW'(j) == ins_pos)
                begin
                    best_dist_reg[j] <= dist_reg;
                    best_slot_reg[j] <= VW'(slot_reg);
                end
                else if ((NW'(j) > ins_pos) && (NW'(j) <= ins_lim))
                begin
                    best_dist_reg[j] <= best_dist_reg[(j > 0) ? j - 1 : 0];
                    best_slot_reg[j] <= best_slot_reg[(j > 0) ? j - 1 : 0];
                end
            end
        end

        if (state_reg == S_EMIT)
        begin
            pend_dist_reg <= best_dist_reg[emit_idx_reg[JW-1:0]];
            pend_rank_reg <= 4'(emit_idx_reg);
            pend_last_reg <= ((emit_idx_reg + NW'(1)) == best_count_reg);
        end

        // result register: neighbor transfer takes the id read issued in the cycle before
        if (pend_reg)
        begin
            result_reg.kind      <= KIND_NEIGHBOR;
            result_reg.status    <= ST_OK;
            result_reg.result_id <= id_rdata;
            result_reg.distance  <= pend_dist_reg;
            result_reg.rank      <= pend_rank_reg;
            result_reg.last      <= pend_last_reg;
        end
        else if (emit_status)
        begin
            result_reg.kind      <= KIND_STATUS;
            result_reg.status    <= stat;
            result_reg.result_id <= '0;
            result_reg.distance  <= '0;
            result_reg.rank      <= '0;
            result_reg.last      <= 1'b1;
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    // list never grows past the capped neighbor count
    assert property (@(posedge clk) disable iff (!rst_n) best_count_reg <= kk_reg)
        else $error("best list longer than requested neighbor count");

    // every pending neighbor read turns into a neighbor transfer next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |=> (result_valid_reg && (result_reg.kind == KIND_NEIGHBOR)))
        else $error("neighbor transfer lost");

    // during a search only neighbor transfers leave the block
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg != S_IDLE) && result_valid_reg) |-> $past(pend_reg))
        else $error("status transfer during search");

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CW'(MAX_VECTORS))
        else $error("store fill count overflow");

endmodule
